FILE: rtl/gps_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and frame tables for the game pad poll sequencer.
package gps_pkg;

   // Frame and queue sizing
   localparam int MAIN_FRAME_BYTES = 21;
   localparam int CMD_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH  = 2;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RECONFIG_PERIOD   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ANALOG_ENABLE     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MOTORS_ENABLE     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SMALL_MOTOR_ON    = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LARGE_MOTOR_POWER = 3'd4;

   // Configuration reset values
   localparam logic [15:0] RECONFIG_PERIOD_RESET = 16'd50;

   // Input event codes
   localparam logic [1:0] MODE_POLL = 2'd0;
   localparam logic [1:0] MODE_BYTE = 2'd1;
   localparam logic [1:0] MODE_FAIL = 2'd2;

   // Protocol bytes
   localparam logic [7:0]  ID_ANALOG    = 8'h73;
   localparam logic [7:0]  STICK_IDLE   = 8'd128;
   localparam logic [15:0] BUTTONS_IDLE = 16'hFFFF;
   localparam logic [15:0] COUNT_TOP    = 16'hFFFF;

   localparam logic [7:0] ENTER_BYTES [5] = '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00};
   localparam logic [7:0] MOTOR_BYTES [9] =
      '{8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
   localparam logic [7:0] ANALOG_BYTES [9] =
      '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] EXIT_BYTES [9] =
      '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A};
   localparam logic [7:0] MAIN_HEAD   = 8'h01;
   localparam logic [7:0] MAIN_POLL   = 8'h42;
   localparam logic [7:0] MOTOR_FULL  = 8'hFF;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_POLL,
      CMD_BYTE,
      CMD_FAIL
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ENTER,
      PH_MOTORS,
      PH_ANALOG,
      PH_EXIT,
      PH_MAIN
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        frame_first;
      logic        frame_final;
      logic        report_valid;
      logic        failed;
      logic [15:0] button_bits;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] rx_byte;
   } cmd_item_type;

   typedef struct packed {
      logic                     we;
      logic [CSR_ADDR_BITS-1:0] addr;
      logic [CSR_DATA_BITS-1:0] data;
   } csr_write_type;

   // Length of a frame in bytes
   function automatic logic [4:0] frame_len(phase_type ph);
      case (ph)
         PH_ENTER: frame_len = 5'd5;
         PH_MAIN:  frame_len = 5'(MAIN_FRAME_BYTES);
         default:  frame_len = 5'd9;
      endcase
   endfunction

   // Command byte at a position of a frame
   function automatic logic [7:0] frame_byte(phase_type ph, logic [4:0] pos,
                                             logic small_on, logic [7:0] large_pwr);
      logic [7:0] b;
      b = 8'h00;
      case (ph)
         PH_ENTER:  if (pos < 5'd5) b = ENTER_BYTES[pos[2:0]];
         PH_MOTORS: if (pos < 5'd9) b = MOTOR_BYTES[pos[3:0]];
         PH_ANALOG: if (pos < 5'd9) b = ANALOG_BYTES[pos[3:0]];
         PH_EXIT:   if (pos < 5'd9) b = EXIT_BYTES[pos[3:0]];
         PH_MAIN: begin
            case (pos)
               5'd0:    b = MAIN_HEAD;
               5'd1:    b = MAIN_POLL;
               5'd3:    b = small_on ? MOTOR_FULL : 8'h00;
               5'd4:    b = large_pwr;
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/gps_fifo.sv
`timescale 1ns / 1ps
// Small first-in first-out queue with a full and an empty flag.
module gps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/gps_front.sv
`timescale 1ns / 1ps
// Front end: decodes incoming events into commands and queues them.
module gps_front
   import gps_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_type      req_data,
   output logic         req_full,
   input  logic         cmd_pop,
   output cmd_item_type cmd_item,
   output logic         cmd_valid
);

   cmd_item_type                      cmd_new;
   logic [$bits(cmd_item_type)-1:0]   cmd_raw;
   logic                              cmd_empty;

   // Classify the event; unknown codes become no-ops
   always_comb begin
      cmd_new.rx_byte = req_data.rx_byte;
      case (req_data.mode)
         MODE_POLL: cmd_new.cmd = CMD_POLL;
         MODE_BYTE: cmd_new.cmd = CMD_BYTE;
         MODE_FAIL: cmd_new.cmd = CMD_FAIL;
         default:   cmd_new.cmd = CMD_NOP;
      endcase
   end

   gps_fifo #(
      .WIDTH ($bits(cmd_item_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_new),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_raw),
      .empty     (cmd_empty)
   );

   assign cmd_item  = cmd_raw;
   assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/gps_engine.sv
`timescale 1ns / 1ps
// Back end: frame sequencer, reply capture and configuration registers.
module gps_engine
   import gps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          cmd_valid,
   input  cmd_item_type  cmd_item,
   output logic          cmd_pop,
   input  logic          rsp_full,
   output logic          rsp_push,
   output rsp_type       rsp_item
);

   // Configuration
   logic [15:0] period_ff;
   logic        analog_en_ff;
   logic        motors_en_ff;
   logic        small_on_ff;
   logic [7:0]  large_pwr_ff;

   // Sequencer state
   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] buttons_ff, buttons_in;
   logic [7:0]  sticks_ff [4];
   logic [7:0]  sticks_in [4];
   logic [7:0]  reply_id_ff, reply_id_in;

   logic        go;
   logic [15:0] count_inc;
   logic [4:0]  pos_next;
   phase_type   start_ph;
   logic        start;
   logic        stick_live;

   assign go       = cmd_valid && !rsp_full;
   assign cmd_pop  = go;
   assign rsp_push = go;
   assign pos_next = pos_ff + 5'd1;
   assign stick_live = analog_en_ff && (reply_id_ff == ID_ANALOG);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= RECONFIG_PERIOD_RESET;
         analog_en_ff <= 1'b1;
         motors_en_ff <= 1'b0;
         small_on_ff  <= 1'b0;
         large_pwr_ff <= 8'h00;
      end else if (csr.we) begin
         case (csr.addr)
            CSR_RECONFIG_PERIOD:   period_ff    <= csr.data;
            CSR_ANALOG_ENABLE:     analog_en_ff <= csr.data[0];
            CSR_MOTORS_ENABLE:     motors_en_ff <= csr.data[0];
            CSR_SMALL_MOTOR_ON:    small_on_ff  <= csr.data[0];
            CSR_LARGE_MOTOR_POWER: large_pwr_ff <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         pos_ff      <= '0;
         count_ff    <= '0;
         buttons_ff  <= BUTTONS_IDLE;
         reply_id_ff <= '0;
         for (int k = 0; k < 4; k++) sticks_ff[k] <= STICK_IDLE;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         count_ff    <= count_in;
         buttons_ff  <= buttons_in;
         reply_id_ff <= reply_id_in;
         for (int k = 0; k < 4; k++) sticks_ff[k] <= sticks_in[k];
      end
   end

   // Next state and result for the command at the queue head
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      buttons_in  = buttons_ff;
      reply_id_in = reply_id_ff;
      for (int k = 0; k < 4; k++) sticks_in[k] = sticks_ff[k];
      rsp_item    = '0;
      start       = 1'b0;
      start_ph    = PH_IDLE;
      count_inc   = (count_ff != COUNT_TOP) ? count_ff + 16'd1 : count_ff;

      if (go) begin
         case (cmd_item.cmd)
            CMD_POLL: begin
               if (phase_ff == PH_IDLE) begin
                  start    = 1'b1;
                  start_ph = PH_MAIN;
                  if (analog_en_ff || motors_en_ff) begin
                     count_in = count_inc;
                     if (count_inc > period_ff) start_ph = PH_ENTER;
                  end
               end
            end
            CMD_FAIL: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in   = PH_IDLE;
                  pos_in     = '0;
                  buttons_in = BUTTONS_IDLE;
                  for (int k = 0; k < 4; k++) sticks_in[k] = STICK_IDLE;
                  rsp_item.failed = 1'b1;
               end
            end
            CMD_BYTE: begin
               if (phase_ff != PH_IDLE) begin
                  // Capture reply bytes of the main frame
                  if (phase_ff == PH_MAIN) begin
                     if (pos_ff == 5'd1) reply_id_in = cmd_item.rx_byte;
                     if (pos_ff == 5'd3) buttons_in[15:8] = cmd_item.rx_byte;
                     if (pos_ff == 5'd4) buttons_in[7:0] = cmd_item.rx_byte;
                     for (int k = 0; k < 4; k++) begin
                        if (pos_ff == 5'(5 + k)) begin
                           sticks_in[k] = stick_live ? cmd_item.rx_byte : STICK_IDLE;
                        end
                     end
                  end
                  if ({1'b0, pos_ff} + 6'd1 < {1'b0, frame_len(phase_ff)}) begin
                     pos_in = pos_next;
                     rsp_item.tx_valid    = 1'b1;
                     rsp_item.tx_byte     =
                        frame_byte(phase_ff, pos_next, small_on_ff, large_pwr_ff);
                     rsp_item.frame_final = (pos_next + 5'd1 == frame_len(phase_ff));
                  end else begin
                     case (phase_ff)
                        PH_ENTER: begin
                           start    = 1'b1;
                           start_ph = motors_en_ff ? PH_MOTORS :
                                      (analog_en_ff ? PH_ANALOG : PH_EXIT);
                        end
                        PH_MOTORS: begin
                           start    = 1'b1;
                           start_ph = analog_en_ff ? PH_ANALOG : PH_EXIT;
                        end
                        PH_ANALOG: begin
                           start    = 1'b1;
                           start_ph = PH_EXIT;
                        end
                        PH_EXIT: begin
                           start    = 1'b1;
                           start_ph = PH_MAIN;
                           count_in = '0;
                        end
                        default: begin
                           phase_in = PH_IDLE;
                           pos_in   = '0;
                           rsp_item.report_valid = 1'b1;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      // Open a new frame at byte zero
      if (start) begin
         phase_in             = start_ph;
         pos_in               = '0;
         rsp_item.tx_valid    = 1'b1;
         rsp_item.tx_byte     = frame_byte(start_ph, 5'd0, small_on_ff, large_pwr_ff);
         rsp_item.frame_first = 1'b1;
         rsp_item.frame_final = (frame_len(start_ph) == 5'd1);
      end

      // Show the held report with a finished or failed poll
      if (rsp_item.report_valid || rsp_item.failed) begin
         rsp_item.button_bits = buttons_in;
         rsp_item.right_x     = sticks_in[0];
         rsp_item.right_y     = sticks_in[1];
         rsp_item.left_x      = sticks_in[2];
         rsp_item.left_y      = sticks_in[3];
      end
   end

endmodule

FILE: rtl/gamepad_poll_sequencer.sv
`timescale 1ns / 1ps
// Top level of the game pad poll sequencer.
//
//   channel   ports                          moves
//   request   req_push / req_full / req_data  one event: mode and received byte
//   response  rsp_pop / rsp_empty / rsp_data  one result per event
//   csr       csr_we / csr_addr / csr_wdata   register write, no wait
//
// One event per cycle is sustained while the response queue has room; the
// frame sequencer retires one command per cycle unless that queue is full. An
// event is registered in the command queue, its result in the response queue.
// Synchronous active-high reset empties both queues and loads register defaults.
// A held response fills the response queue, then stalls the sequencer, then
// the command queue raises req_full; no item is dropped.
module gamepad_poll_sequencer
   import gps_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  req_type                  req_data,
   output logic                     req_full,
   input  logic                     rsp_pop,
   output rsp_type                  rsp_data,
   output logic                     rsp_empty,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   csr_write_type               csr;
   cmd_item_type                cmd_item;
   logic                        cmd_valid;
   logic                        cmd_pop;
   logic                        rsp_full;
   logic                        rsp_push;
   rsp_type                     rsp_item;
   logic [$bits(rsp_type)-1:0]  rsp_raw;

   assign csr.we   = csr_we;
   assign csr.addr = csr_addr;
   assign csr.data = csr_wdata;

   gps_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_item),
      .cmd_valid (cmd_valid)
   );

   gps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   gps_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_raw),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_raw;

endmodule

FILE: rtl/gps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the game pad poll sequencer, bound to the top level.
module gps_checker
   import gps_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_pop,
   input rsp_type rsp_data,
   input logic    rsp_empty
);

   // Reset leaves both queues empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // Hold a waiting result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

   // Transmit, report and failure never share a result
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.report_valid && rsp_data.failed) &&
                     !(rsp_data.tx_valid && (rsp_data.report_valid || rsp_data.failed)))
      else $error("result mixes transmit and report");

   // Zero the transmit fields when nothing is sent
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.tx_valid |->
         rsp_data.tx_byte == 8'h00 && !rsp_data.frame_first && !rsp_data.frame_final)
      else $error("transmit fields set without a transmit byte");

   // A failure reports idle pad values
   a_fail_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.failed |->
         rsp_data.button_bits == BUTTONS_IDLE &&
         rsp_data.right_x == STICK_IDLE && rsp_data.right_y == STICK_IDLE &&
         rsp_data.left_x == STICK_IDLE && rsp_data.left_y == STICK_IDLE)
      else $error("failure without idle values");

endmodule

bind gamepad_poll_sequencer gps_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty)
);

FILE: sim/tb_gamepad_poll_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the game pad poll sequencer: scripted and random events.
module tb_gamepad_poll_sequencer;
   import gps_pkg::*;

   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam logic [7:0]  PAD_ID_ANALOG = 8'h73;
   localparam logic [7:0]  STICK_REST    = 8'd128;
   localparam logic [15:0] BUTTONS_REST  = 16'hFFFF;
   localparam logic [15:0] TALLY_TOP     = 16'hFFFF;

   // Command bytes of the configuration frames, first byte in the top lane
   localparam logic [39:0] ENTER_SEQ  = 40'h01_43_00_01_00;
   localparam logic [71:0] MOTOR_SEQ  = 72'h01_4D_00_00_01_FF_FF_FF_FF;
   localparam logic [71:0] ANALOG_SEQ = 72'h01_44_00_01_03_00_00_00_00;
   localparam logic [71:0] EXIT_SEQ   = 72'h01_43_00_00_5A_5A_5A_5A_5A;

   localparam int RANDOM_PER_SETTING = 190;
   localparam int HOLD_OFF_CYCLES    = 300;

   typedef struct packed {
      logic [15:0] period;
      logic        analog;
      logic        motors;
      logic        small_on;
      logic [7:0]  large_pwr;
   } pad_setting_type;

   typedef struct packed {
      req_type item;
      logic    fixed;
      rsp_type want;
   } script_step_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   req_type                  req_data = '0;
   logic                     req_full;
   logic                     rsp_pop = 1'b0;
   rsp_type                  rsp_data;
   logic                     rsp_empty;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Predictor configuration and state
   logic [15:0] cfg_period;
   logic        cfg_analog;
   logic        cfg_motors;
   logic        cfg_small;
   logic [7:0]  cfg_large;
   phase_type   pad_phase;
   int          pad_pos;
   logic [15:0] poll_tally;
   logic [15:0] held_btn;
   logic [7:0]  held_stk [4];
   logic [7:0]  pad_id;

   rsp_type awaited_results [$];
   int      errors = 0;
   int      req_calm = 0;
   int      rsp_calm = 0;

   gamepad_poll_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int frame_bytes(phase_type ph);
      if (ph == PH_ENTER) return 5;
      if (ph == PH_MAIN) return MAIN_FRAME_BYTES;
      return 9;
   endfunction

   function automatic logic [7:0] byte_for(phase_type ph, int pos);
      case (ph)
         PH_ENTER:  return ENTER_SEQ[39 - 8*pos -: 8];
         PH_MOTORS: return MOTOR_SEQ[71 - 8*pos -: 8];
         PH_ANALOG: return ANALOG_SEQ[71 - 8*pos -: 8];
         PH_EXIT:   return EXIT_SEQ[71 - 8*pos -: 8];
         default: begin
            case (pos)
               0:       return 8'h01;
               1:       return 8'h42;
               3:       return cfg_small ? 8'hFF : 8'h00;
               4:       return cfg_large;
               default: return 8'h00;
            endcase
         end
      endcase
   endfunction

   function automatic rsp_type emit(phase_type ph, int pos);
      rsp_type r;
      r = '0;
      r.tx_valid    = 1'b1;
      r.tx_byte     = byte_for(ph, pos);
      r.frame_first = (pos == 0);
      r.frame_final = (pos + 1 == frame_bytes(ph));
      return r;
   endfunction

   function automatic rsp_type begin_frame(phase_type ph);
      pad_phase = ph;
      pad_pos   = 0;
      return emit(ph, 0);
   endfunction

   function automatic rsp_type with_held(rsp_type r);
      r.button_bits = held_btn;
      r.right_x     = held_stk[0];
      r.right_y     = held_stk[1];
      r.left_x      = held_stk[2];
      r.left_y      = held_stk[3];
      return r;
   endfunction

   function automatic void rest_values();
      held_btn = BUTTONS_REST;
      for (int k = 0; k < 4; k++) held_stk[k] = STICK_REST;
   endfunction

   function automatic void pad_reset();
      cfg_period = 16'd50;
      cfg_analog = 1'b1;
      cfg_motors = 1'b0;
      cfg_small  = 1'b0;
      cfg_large  = 8'd0;
      pad_phase  = PH_IDLE;
      pad_pos    = 0;
      poll_tally = '0;
      pad_id     = '0;
      rest_values();
   endfunction

   // Capture reply bytes of the main frame into the held report
   function automatic void take_reply(int pos, logic [7:0] rx);
      if (pos == 1) pad_id = rx;
      else if (pos == 3) held_btn[15:8] = rx;
      else if (pos == 4) held_btn[7:0] = rx;
      else if (pos >= 5 && pos <= 8)
         held_stk[pos-5] = (cfg_analog && pad_id == PAD_ID_ANALOG) ? rx : STICK_REST;
   endfunction

   // Advance the predicted sequencer by one event and return its result
   function automatic rsp_type pad_step(req_type it);
      rsp_type r;
      r = '0;
      case (it.mode)
         MODE_POLL: begin
            if (pad_phase == PH_IDLE) begin
               if ((cfg_analog || cfg_motors) && poll_tally != TALLY_TOP)
                  poll_tally = poll_tally + 16'd1;
               if ((cfg_analog || cfg_motors) && poll_tally > cfg_period)
                  r = begin_frame(PH_ENTER);
               else
                  r = begin_frame(PH_MAIN);
            end
         end
         MODE_FAIL: begin
            if (pad_phase != PH_IDLE) begin
               pad_phase = PH_IDLE;
               pad_pos   = 0;
               rest_values();
               r.failed = 1'b1;
               r = with_held(r);
            end
         end
         MODE_BYTE: begin
            if (pad_phase != PH_IDLE) begin
               if (pad_phase == PH_MAIN) take_reply(pad_pos, it.rx_byte);
               if (pad_pos + 1 < frame_bytes(pad_phase)) begin
                  pad_pos = pad_pos + 1;
                  r = emit(pad_phase, pad_pos);
               end else begin
                  case (pad_phase)
                     PH_ENTER:
                        r = begin_frame(cfg_motors ? PH_MOTORS :
                                        (cfg_analog ? PH_ANALOG : PH_EXIT));
                     PH_MOTORS: r = begin_frame(cfg_analog ? PH_ANALOG : PH_EXIT);
                     PH_ANALOG: r = begin_frame(PH_EXIT);
                     PH_EXIT: begin
                        poll_tally = '0;
                        r = begin_frame(PH_MAIN);
                     end
                     default: begin
                        pad_phase = PH_IDLE;
                        pad_pos   = 0;
                        r.report_valid = 1'b1;
                        r = with_held(r);
                     end
                  endcase
               end
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Draw a wait: mostly a uniformly drawn gap, with stretches of back-to-back items
   task automatic pick_wait(inout int calm, output int gap);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(10, 40);
         gap  = 0;
      end else begin
         gap = $urandom_range(0, 16);
      end
   endtask

   // Offer one item, hold it until taken, and predict its result
   task automatic send_item(input req_type item, output rsp_type predicted);
      int gap;
      pick_wait(req_calm, gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      predicted = pad_step(item);
   endtask

   // Mostly well-formed traffic: polls when idle, bytes inside a frame
   function automatic req_type make_item();
      req_type it;
      int      pick;
      pick = $urandom_range(0, 99);
      it.rx_byte = 8'($urandom_range(0, 255));
      if (pad_phase == PH_IDLE)
         it.mode = (pick < 80) ? MODE_POLL : (pick < 88) ? MODE_BYTE :
                   (pick < 95) ? MODE_FAIL : MODE_UNUSED;
      else
         it.mode = (pick < 94) ? MODE_BYTE : (pick < 96) ? MODE_FAIL :
                   (pick < 98) ? MODE_POLL : MODE_UNUSED;
      if (pad_phase == PH_MAIN && pad_pos == 1 && $urandom_range(0, 1) == 1)
         it.rx_byte = PAD_ID_ANALOG;
      return it;
   endfunction

   task automatic random_block(input int count);
      rsp_type got;
      int      useful;
      useful = 0;
      while (useful < count) begin
         send_item(make_item(), got);
         awaited_results.push_back(got);
         if (got != '0) useful++;
      end
   endtask

   // Drop the request and wait until every result is back
   task automatic drain();
      req_push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all five registers while the block is idle
   task automatic apply_setting(input pad_setting_type s);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_RECONFIG_PERIOD;
      csr_wdata <= s.period;
      @(posedge clock);
      csr_addr  <= CSR_ANALOG_ENABLE;
      csr_wdata <= CSR_DATA_BITS'(s.analog);
      @(posedge clock);
      csr_addr  <= CSR_MOTORS_ENABLE;
      csr_wdata <= CSR_DATA_BITS'(s.motors);
      @(posedge clock);
      csr_addr  <= CSR_SMALL_MOTOR_ON;
      csr_wdata <= CSR_DATA_BITS'(s.small_on);
      @(posedge clock);
      csr_addr  <= CSR_LARGE_MOTOR_POWER;
      csr_wdata <= CSR_DATA_BITS'(s.large_pwr);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_period = s.period;
      cfg_analog = s.analog;
      cfg_motors = s.motors;
      cfg_small  = s.small_on;
      cfg_large  = s.large_pwr;
   endtask

   function automatic script_step_type script_row(logic [1:0] mode, logic [7:0] rx,
                                                  logic fixed, rsp_type want);
      script_step_type st;
      st.item.mode    = mode;
      st.item.rx_byte = rx;
      st.fixed        = fixed;
      st.want         = want;
      return st;
   endfunction

   initial begin : stimulus
      script_step_type script [$];
      pad_setting_type plan [7];
      rsp_type         got;
      rsp_type         main_open;
      rsp_type         idle_fail;

      pad_reset();
      main_open = '0;
      main_open.tx_valid    = 1'b1;
      main_open.tx_byte     = 8'h01;
      main_open.frame_first = 1'b1;
      idle_fail = '0;
      idle_fail.failed      = 1'b1;
      idle_fail.button_bits = BUTTONS_REST;
      idle_fail.right_x     = STICK_REST;
      idle_fail.right_y     = STICK_REST;
      idle_fail.left_x      = STICK_REST;
      idle_fail.left_y      = STICK_REST;

      // Ignored events when idle, then a full main frame with extreme replies
      script.push_back(script_row(MODE_BYTE, 8'hFF, 1'b1, '0));
      script.push_back(script_row(MODE_FAIL, 8'h00, 1'b1, '0));
      script.push_back(script_row(MODE_UNUSED, 8'hFF, 1'b1, '0));
      script.push_back(script_row(MODE_POLL, 8'h00, 1'b1, main_open));
      script.push_back(script_row(MODE_POLL, 8'hFF, 1'b1, '0));
      script.push_back(script_row(MODE_BYTE, 8'h00, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, PAD_ID_ANALOG, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'h5A, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'h00, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'hFF, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'h00, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'hFF, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'h00, 1'b0, '0));
      script.push_back(script_row(MODE_BYTE, 8'hFF, 1'b0, '0));
      for (int k = 0; k < 12; k++)
         script.push_back(script_row(MODE_BYTE, 8'hFF, 1'b0, '0));
      // Failure inside a frame shows the idle values
      script.push_back(script_row(MODE_POLL, 8'h00, 1'b1, main_open));
      script.push_back(script_row(MODE_BYTE, 8'h55, 1'b0, '0));
      script.push_back(script_row(MODE_FAIL, 8'hAA, 1'b1, idle_fail));

      plan[0] = '{16'd0,     1'b1, 1'b1, 1'b1, 8'd255};
      plan[1] = '{16'd0,     1'b0, 1'b1, 1'b0, 8'd128};
      plan[2] = '{16'd3,     1'b1, 1'b0, 1'b1, 8'd0};
      plan[3] = '{16'd0,     1'b0, 1'b0, 1'b0, 8'd7};
      plan[4] = '{16'hFFFF,  1'b1, 1'b1, 1'b0, 8'd255};
      plan[5] = '{16'd1,     1'b1, 1'b1, 1'b1, 8'd1};
      plan[6] = '{16'd2,     1'b0, 1'b1, 1'b1, 8'h5A};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send_item(script[i].item, got);
         awaited_results.push_back(script[i].fixed ? script[i].want : got);
      end

      // Random traffic under the reset settings, then under each setting
      random_block(RANDOM_PER_SETTING);
      foreach (plan[i]) begin
         drain();
         apply_setting(plan[i]);
         random_block(RANDOM_PER_SETTING);
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb_gamepad_poll_sequencer passed");
      end else begin
         $display("tb_gamepad_poll_sequencer failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- checking

   task automatic cmp_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Take results with random stalls and two long hold-offs
   initial begin : result_drain
      rsp_type want;
      int      stall;
      int      taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 150 || taken == 900) stall = HOLD_OFF_CYCLES;
         else pick_wait(rsp_calm, stall);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         taken++;
         if (awaited_results.size() == 0) begin
            $display("%0t ns: result %h arrived with nothing expected", $time, rsp_data);
            errors++;
         end else begin
            want = awaited_results.pop_front();
            cmp_field("tx_valid", want.tx_valid, rsp_data.tx_valid);
            cmp_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
            cmp_field("frame_first", want.frame_first, rsp_data.frame_first);
            cmp_field("frame_final", want.frame_final, rsp_data.frame_final);
            cmp_field("report_valid", want.report_valid, rsp_data.report_valid);
            cmp_field("failed", want.failed, rsp_data.failed);
            cmp_field("button_bits", want.button_bits, rsp_data.button_bits);
            cmp_field("right_x", want.right_x, rsp_data.right_x);
            cmp_field("right_y", want.right_y, rsp_data.right_y);
            cmp_field("left_x", want.left_x, rsp_data.left_x);
            cmp_field("left_y", want.left_y, rsp_data.left_y);
         end
      end
   end

   // Stop a hung run
   initial begin : watchdog
      #4_000_000;
      $display("tb_gamepad_poll_sequencer failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/gps_pkg.sv
rtl/gps_fifo.sv
rtl/gps_front.sv
rtl/gps_engine.sv
rtl/gamepad_poll_sequencer.sv
rtl/gps_checker.sv
sim/tb_gamepad_poll_sequencer.sv
